// ===== src/enbis_pkg.sv =====
`timescale 1ns / 1ps

package enbis_pkg;

  localparam int POS_W = 21;
  localparam int HDR_BYTES = 12;
  localparam int NOTE_NAMESZ = 4;
  localparam int BUILD_ID_TYPE = 3;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [POS_W:0] pos1_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] id_byte;
    logic       id_last;
    logic       section_done;
    logic       found;
  } out_item_t;

  function automatic logic [7:0] gnu_tag(input logic [1:0] idx);
    logic [7:0] t;
    case (idx)
      2'd0:    t = 8'h47;
      2'd1:    t = 8'h4E;
      2'd2:    t = 8'h55;
      default: t = 8'h00;
    endcase
    return t;
  endfunction

endpackage

// ===== src/enbis_in_stage.sv =====
`timescale 1ns / 1ps

module enbis_in_stage import enbis_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     sec_valid,
  output logic     sec_stall,
  input  in_item_t sec_item,
  input  logic     hold,
  output logic     s1_valid,
  output in_item_t s1_item
);

  assign sec_stall = s1_valid & hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!sec_stall) begin
      s1_valid <= sec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!sec_stall && sec_valid) begin
      s1_item <= sec_item;
    end
  end

endmodule

// ===== src/enbis_parser.sv =====
`timescale 1ns / 1ps

module enbis_parser import enbis_pkg::*; #(
  parameter int unsigned MAX_SECTION_BYTES = 1048576
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wen,
  input  pos_t      cfg_wdata,
  input  logic      fire,
  input  in_item_t  item,
  output logic      gen_valid,
  output out_item_t gen_item
);

  localparam logic [2:0] PH_HDR  = 3'd0;
  localparam logic [2:0] PH_NAME = 3'd1;
  localparam logic [2:0] PH_PAD  = 3'd2;
  localparam logic [2:0] PH_EMIT = 3'd3;
  localparam logic [2:0] PH_SKIP = 3'd4;
  localparam logic [2:0] PH_STOP = 3'd5;

  pos_t        sec_len;
  pos_t        pos, pos_next;
  logic [2:0]  phase, phase_next;
  logic [87:0] hdr, hdr_next;
  pos_t        hdr_end, hdr_end_next;
  pos_t        name_end, name_end_next;
  pos_t        desc_end, desc_end_next;
  pos1_t       pad_end, pad_end_next;
  pos1_t       desc_pad, desc_pad_next;
  logic [1:0]  name_cnt, name_cnt_next;
  logic        name_match, name_match_next;
  logic        type3, type3_next;
  logic        desc_zero, desc_zero_next;
  logic        found_flag, found_next;

  always_comb begin
    logic [2:0]        ph;
    pos_t              he;
    pos1_t             q;
    pos1_t             len_ext;
    logic [POS_W+1:0]  sh_sum;
    logic              sh_fail;
    logic [31:0]       namesz, descsz, typ;
    pos_t              rem1;
    logic              fail1, fail2;
    pos1_t             ne_w, pe_sum, pe, de_w, dp_sum, dp;
    logic              mismatch, m;
    logic              has, idlast;

    q       = {1'b0, pos} + pos1_t'(1);
    len_ext = {1'b0, sec_len};
    sh_sum  = {1'b0, q} + (POS_W+2)'(HDR_BYTES);
    sh_fail = sh_sum > {2'b00, sec_len};

    if (pos == '0) begin
      he = pos_t'(HDR_BYTES);
      if (found_flag || sec_len == '0 || 32'(sec_len) > 32'(MAX_SECTION_BYTES) ||
          sec_len < pos_t'(HDR_BYTES)) begin
        ph = PH_STOP;
      end else begin
        ph = PH_HDR;
      end
    end else begin
      ph = phase;
      he = hdr_end;
    end

    namesz  = hdr[31:0];
    descsz  = hdr[63:32];
    typ     = {item.data_byte, hdr[87:64]};
    rem1    = sec_len - he;
    fail1   = (he > sec_len) || (|namesz[31:POS_W]) || (namesz[POS_W-1:0] > rem1);
    ne_w    = {1'b0, he} + {1'b0, namesz[POS_W-1:0]};
    pe_sum  = ne_w + pos1_t'(3);
    pe      = {pe_sum[POS_W:2], 2'b00};
    fail2   = (pe > len_ext) || (|descsz[31:POS_W]) ||
              ({1'b0, descsz[POS_W-1:0]} > (len_ext - pe));
    de_w    = pe + {1'b0, descsz[POS_W-1:0]};
    dp_sum  = de_w + pos1_t'(3);
    dp      = {dp_sum[POS_W:2], 2'b00};

    mismatch = (name_cnt != 2'd3) && (item.data_byte != gnu_tag(name_cnt));
    m        = name_match;
    has      = 1'b0;
    idlast   = 1'b0;

    phase_next      = ph;
    hdr_next        = hdr;
    hdr_end_next    = he;
    name_end_next   = name_end;
    desc_end_next   = desc_end;
    pad_end_next    = pad_end;
    desc_pad_next   = desc_pad;
    name_cnt_next   = name_cnt;
    name_match_next = name_match;
    type3_next      = type3;
    desc_zero_next  = desc_zero;
    found_next      = found_flag;

    unique case (ph)
      PH_HDR: begin
        hdr_next = {item.data_byte, hdr[87:8]};
        if (q == {1'b0, he}) begin
          if (fail1 || fail2) begin
            phase_next = PH_STOP;
          end else begin
            name_match_next = (namesz == 32'(NOTE_NAMESZ));
            type3_next      = (typ == 32'(BUILD_ID_TYPE));
            desc_zero_next  = (descsz == '0);
            name_end_next   = ne_w[POS_W-1:0];
            pad_end_next    = pe;
            desc_end_next   = de_w[POS_W-1:0];
            desc_pad_next   = dp;
            name_cnt_next   = 2'd0;
            if (namesz != '0) begin
              phase_next = PH_NAME;
            end else if (descsz != '0) begin
              phase_next = PH_SKIP;
            end else if (sec_len < pos_t'(HDR_BYTES) || he > sec_len - pos_t'(HDR_BYTES)) begin
              phase_next = PH_STOP;
            end else begin
              phase_next   = PH_HDR;
              hdr_end_next = he + pos_t'(HDR_BYTES);
            end
          end
        end
      end
      PH_NAME, PH_PAD: begin
        if (ph == PH_NAME) begin
          m               = name_match & ~mismatch;
          name_match_next = m;
          name_cnt_next   = (name_cnt == 2'd3) ? name_cnt : name_cnt + 2'd1;
          if (q == {1'b0, name_end}) begin
            phase_next = PH_PAD;
          end
        end
        if ((ph == PH_PAD || q == {1'b0, name_end}) && q == pad_end) begin
          if (m && type3) begin
            phase_next = desc_zero ? PH_STOP : PH_EMIT;
          end else if (!desc_zero) begin
            phase_next = PH_SKIP;
          end else if (sh_fail) begin
            phase_next = PH_STOP;
          end else begin
            phase_next   = PH_HDR;
            hdr_end_next = sh_sum[POS_W-1:0];
          end
        end
      end
      PH_EMIT: begin
        has    = 1'b1;
        idlast = (q == {1'b0, desc_end});
        if (idlast) begin
          found_next = 1'b1;
          phase_next = PH_STOP;
        end
      end
      PH_SKIP: begin
        if (q == desc_pad) begin
          if (sh_fail) begin
            phase_next = PH_STOP;
          end else begin
            phase_next   = PH_HDR;
            hdr_end_next = sh_sum[POS_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase

    if (item.last_byte) begin
      pos_next   = '0;
      phase_next = PH_HDR;
    end else if (pos == POS_MAX) begin
      pos_next = pos;
    end else begin
      pos_next = q[POS_W-1:0];
    end

    gen_valid             = has | item.last_byte;
    gen_item.has_byte     = has;
    gen_item.id_byte      = has ? item.data_byte : 8'h00;
    gen_item.id_last      = idlast;
    gen_item.section_done = item.last_byte;
    gen_item.found        = item.last_byte & found_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sec_len <= '0;
    end else if (cfg_wen) begin
      sec_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      phase      <= PH_HDR;
      found_flag <= 1'b0;
    end else if (fire) begin
      pos        <= pos_next;
      phase      <= phase_next;
      found_flag <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hdr        <= hdr_next;
      hdr_end    <= hdr_end_next;
      name_end   <= name_end_next;
      desc_end   <= desc_end_next;
      pad_end    <= pad_end_next;
      desc_pad   <= desc_pad_next;
      name_cnt   <= name_cnt_next;
      name_match <= name_match_next;
      type3      <= type3_next;
      desc_zero  <= desc_zero_next;
    end
  end

endmodule

// ===== src/enbis_out_reg.sv =====
`timescale 1ns / 1ps

module enbis_out_reg import enbis_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  logic      gen_valid,
  input  out_item_t gen_item,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item,
  output logic      hold
);

  assign hold = res_valid & res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= gen_valid;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && gen_valid) begin
      res_item <= gen_item;
    end
  end

endmodule

// ===== src/elf_note_build_id_scanner.sv =====
// A byte is registered in the input stage, and its result item in the output register.
// Throughput: 1 byte per cycle while no stalled result is held; all header, name and
// descriptor bookkeeping for a byte is one compare/add pass against the position
// counter between the registers. Bytes causing no result are consumed with no item.
// Reset (rst, synchronous): clears section_length, position, phase and the found flag.
`timescale 1ns / 1ps

module elf_note_build_id_scanner import enbis_pkg::*; #(
  parameter int unsigned MAX_SECTION_BYTES = 1048576
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wen,
  input  pos_t      cfg_wdata,
  input  logic      sec_valid,
  output logic      sec_stall,
  input  in_item_t  sec_item,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  logic      hold;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      fire;
  logic      gen_valid;
  out_item_t gen_item;

  assign fire = s1_valid & ~hold;

  enbis_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .sec_valid (sec_valid),
    .sec_stall (sec_stall),
    .sec_item  (sec_item),
    .hold      (hold),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item)
  );

  enbis_parser #(
    .MAX_SECTION_BYTES (MAX_SECTION_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (s1_item),
    .gen_valid (gen_valid),
    .gen_item  (gen_item)
  );

  enbis_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .gen_valid (gen_valid),
    .gen_item  (gen_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .hold      (hold)
  );

endmodule

// ===== src/enbis_checker.sv =====
`timescale 1ns / 1ps

module enbis_checker import enbis_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      res_valid,
  input logic      res_stall,
  input out_item_t res_item
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("stalled result item changed");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.has_byte |-> res_item.id_byte == 8'h00 && !res_item.id_last)
    else $error("id fields set without a build-id byte");

  a_found_close: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.found |-> res_item.section_done)
    else $error("found reported outside section close");

  a_no_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.has_byte || res_item.section_done)
    else $error("result item carries neither a byte nor a close");

endmodule

bind elf_note_build_id_scanner enbis_checker u_chk (.*);
